[rtl/sor_linear_solver_macros.svh]
// Assertion macros for the SOR solver RTL.
// Included by modules that check their own behaviour; no other dependencies.
`ifndef SOR_LINEAR_SOLVER_MACROS_SVH
`define SOR_LINEAR_SOLVER_MACROS_SVH

`ifndef SYNTHESIS
`define SOR_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("SOR check failed");
`define SOR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("SOR check failed");
`else
`define SOR_ASSERT_ALWAYS(label, clk, rstn, expr)
`define SOR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[rtl/sor_pkg.sv]
// Shared types and constants for the SOR linear solver.
// No dependencies.
package sor_pkg;

    localparam int MAX_VARS   = 16;
    localparam int COLS       = MAX_VARS + 1;
    localparam int MAT_DEPTH  = MAX_VARS * COLS;
    localparam int MAT_AW     = 9;
    localparam int SOL_AW     = 4;
    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_W      = 53;
    localparam int RES_W      = 47;   // residual clamp: 63 - FRAC_BITS bits signed
    localparam int DIVD_W     = 63;
    localparam int CHG_W      = 40;

    localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        REG_VARS  = 2'd0,
        REG_RELAX = 2'd1,
        REG_TOL   = 2'd2,
        REG_LIMIT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_LIMIT     = 2'd1,
        ST_ZERO_DIAG = 2'd2
    } solve_status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_CHK, S_DECIDE,
        S_ROW, S_ROWD, S_RD, S_MUL, S_ACC,
        S_DIAG, S_DIVLD, S_DIV, S_STEP, S_UPD, S_SWEND,
        S_ORD, S_OLD, S_OWAIT
    } sor_state_t;

    typedef struct packed {
        logic start;
        logic [DIVD_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    // row * COLS + col for COLS = 17
    function automatic logic [MAT_AW-1:0] mat_addr(input logic [3:0] row,
                                                   input logic [4:0] col);
        return {1'b0, row, 4'b0000} + {5'b0, row} + {4'b0, col};
    endfunction

endpackage

[rtl/sor_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sor_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on sor_pkg.
module sor_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  sor_pkg::div_req_t req,
    output sor_pkg::div_rsp_t rsp
);
    import sor_pkg::*;

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DATA_W'(trial - {1'b0, dvs_reg}) : trial[DATA_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start) begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/sor_linear_solver.sv]
// Top level of the SOR linear solver: sequencer, datapath and memories.
// Depends on sor_pkg, sor_ram, sor_div and sor_linear_solver_macros.svh.
//
// Coefficient loads (tuser = 0) are taken one per cycle and written into the
// matrix memory. A start transfer (tuser = 1) runs the whole solve and the
// block takes no input until every result has been transferred. Start-up
// sets the unknowns to one and checks the diagonal. Each row of a sweep
// forms its products one at a time through the shared multiplier, each
// after the registered memory read, and then runs the bit-serial divider.
// A sweep is N rows followed by the end-of-sweep check. Results then leave
// one at a time, and the next is read only once the last has been taken.
module sor_linear_solver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // row_index[3:0], col_index[8:4], coeff_value[40:9]
    input  logic        s_tuser,    // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // var_index[3:0], var_value[35:4], sweeps_done[43:36]
    output logic        m_tlast,
    output logic [1:0]  m_tuser,    // solve_status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [16:0] cfg_wdata
);
    import sor_pkg::*;

    sor_state_t state_reg, state_next;

    logic [4:0]  vars_reg;
    logic [16:0] relax_reg;
    logic [15:0] tol_reg;
    logic [7:0]  limit_reg;

    logic [4:0]  n_eff, n_last;
    logic [4:0]  i_reg, j_reg;
    logic        zero_reg;
    logic [1:0]  status_reg;
    logic [7:0]  sweep_reg;
    logic [CHG_W-1:0] change_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] old_reg, q_reg;
    logic signed [63:0] prod_reg;
    logic signed [50:0] step_reg;
    logic        q_neg_reg;

    logic        out_valid_reg;
    logic [3:0]  out_idx_reg;
    logic [DATA_W-1:0] out_val_reg;
    logic        out_last_reg;

    // memory ports
    logic              mat_we;
    logic [MAT_AW-1:0] mat_waddr, mat_raddr;
    logic [DATA_W-1:0] mat_rdata;
    logic              sol_we;
    logic [SOL_AW-1:0] sol_waddr, sol_raddr;
    logic [DATA_W-1:0] sol_wdata, sol_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [3:0]  in_row;
    logic [4:0]  in_col;
    logic        s_hs, m_hs;

    // datapath terms
    logic signed [RES_W-1:0]  res_sat;
    logic [RES_W-1:0]         res_mag;
    logic [DATA_W-1:0]        diag_mag;
    logic signed [DATA_W-1:0] q_sat;
    logic signed [DATA_W:0]   diff;
    logic signed [35:0]       nv_wide;
    logic signed [DATA_W-1:0] nv;
    logic signed [DATA_W+1:0] delta;
    logic [DATA_W:0]          delta_abs;
    logic [CHG_W-1:0]         change_new;
    logic [7:0]               sweep_inc;

    assign in_row = s_tdata[3:0];
    assign in_col = s_tdata[8:4];
    assign s_hs   = s_tvalid && s_tready;
    assign m_hs   = out_valid_reg && m_tready;

    assign n_eff  = (vars_reg == 5'd0) ? 5'd1 :
                    (vars_reg > 5'(MAX_VARS)) ? 5'(MAX_VARS) : vars_reg;
    assign n_last = n_eff - 5'd1;

    sor_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_mat (
        .aclk (aclk), .we (mat_we), .waddr (mat_waddr), .wdata (s_tdata[40:9]),
        .raddr (mat_raddr), .rdata (mat_rdata)
    );

    sor_ram #(.WIDTH(DATA_W), .DEPTH(MAX_VARS)) u_sol (
        .aclk (aclk), .we (sol_we), .waddr (sol_waddr), .wdata (sol_wdata),
        .raddr (sol_raddr), .rdata (sol_rdata)
    );

    sor_div u_div (.aclk (aclk), .aresetn (aresetn), .req (div_req), .rsp (div_rsp));

    // residual clamp and operand magnitudes for the divider
    always_comb begin
        if (acc_reg > ACC_W'(signed'({1'b0, {(RES_W-1){1'b1}}}))) begin
            res_sat = {1'b0, {(RES_W-1){1'b1}}};
        end else if (acc_reg < -ACC_W'(signed'({1'b0, 1'b1, {(RES_W-1){1'b0}}}))) begin
            res_sat = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            res_sat = acc_reg[RES_W-1:0];
        end
        res_mag  = res_sat[RES_W-1] ? RES_W'(-res_sat) : RES_W'(res_sat);
        diag_mag = mat_rdata[DATA_W-1] ? DATA_W'(-mat_rdata) : mat_rdata;
    end

    // quotient saturation, toward zero already
    always_comb begin
        if (!q_neg_reg) begin
            q_sat = (div_rsp.quotient > DIVD_W'({1'b0, {(DATA_W-1){1'b1}}})) ?
                    {1'b0, {(DATA_W-1){1'b1}}} : div_rsp.quotient[DATA_W-1:0];
        end else begin
            q_sat = (div_rsp.quotient > DIVD_W'({1'b1, {(DATA_W-1){1'b0}}})) ?
                    {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(-div_rsp.quotient[DATA_W-1:0]);
        end
    end

    assign diff    = (DATA_W+1)'(q_reg) - (DATA_W+1)'(old_reg);
    assign nv_wide = 36'(old_reg) + 36'(signed'(step_reg[50:FRAC_BITS]));
    assign nv      = (nv_wide > 36'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) ?
                     {1'b0, {(DATA_W-1){1'b1}}} :
                     (nv_wide < -36'(signed'({1'b0, 1'b1, {(DATA_W-1){1'b0}}}))) ?
                     {1'b1, {(DATA_W-1){1'b0}}} : nv_wide[DATA_W-1:0];
    assign delta     = (DATA_W+2)'(nv) - (DATA_W+2)'(old_reg);
    assign delta_abs = delta[DATA_W+1] ? (DATA_W+1)'(-delta) : delta[DATA_W:0];
    assign change_new = change_reg + CHG_W'(delta_abs);
    assign sweep_inc  = sweep_reg + 8'd1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_hs && s_tuser) state_next = S_INIT;
            S_INIT:   state_next = S_CHK;
            S_CHK:    state_next = (i_reg == n_last) ? S_DECIDE : S_INIT;
            S_DECIDE: begin
                if (zero_reg || mat_rdata == '0 || limit_reg == 8'd0) begin
                    state_next = S_ORD;
                end else begin
                    state_next = S_ROW;
                end
            end
            S_ROW:    state_next = S_ROWD;
            S_ROWD:   state_next = S_RD;
            S_RD: begin
                if (j_reg == n_eff) state_next = S_DIAG;
                else if (j_reg != i_reg) state_next = S_MUL;
            end
            S_MUL:    state_next = S_ACC;
            S_ACC:    state_next = S_RD;
            S_DIAG:   state_next = S_DIVLD;
            S_DIVLD:  state_next = S_DIV;
            S_DIV:    if (div_rsp.done) state_next = S_STEP;
            S_STEP:   state_next = S_UPD;
            S_UPD:    state_next = (i_reg == n_last) ? S_SWEND : S_ROW;
            S_SWEND: begin
                if (change_reg < CHG_W'(tol_reg) || sweep_inc >= limit_reg) begin
                    state_next = S_ORD;
                end else begin
                    state_next = S_ROW;
                end
            end
            S_ORD:    state_next = S_OLD;
            S_OLD:    state_next = S_OWAIT;
            S_OWAIT: begin
                if (m_tready) state_next = out_last_reg ? S_IDLE : S_ORD;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb begin
        s_tready  = 1'b0;
        mat_we    = 1'b0;
        mat_waddr = mat_addr(in_row, in_col);
        mat_raddr = mat_addr(i_reg[3:0], i_reg);
        sol_we    = 1'b0;
        sol_waddr = i_reg[3:0];
        sol_wdata = ONE_VAL;
        sol_raddr = i_reg[3:0];
        div_req.start    = 1'b0;
        div_req.dividend = {res_mag, {FRAC_BITS{1'b0}}};
        div_req.divisor  = diag_mag;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                mat_we   = s_tvalid && !s_tuser && (in_col <= 5'(MAX_VARS));
            end
            S_INIT: sol_we = 1'b1;
            S_ROW:  mat_raddr = mat_addr(i_reg[3:0], n_eff);
            S_RD: begin
                mat_raddr = mat_addr(i_reg[3:0], j_reg);
                sol_raddr = j_reg[3:0];
            end
            S_DIVLD: div_req.start = 1'b1;
            S_UPD: begin
                sol_we    = 1'b1;
                sol_wdata = nv;
            end
            default: ;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            vars_reg      <= 5'd3;
            relax_reg     <= 17'd62925;
            tol_reg       <= 16'd7;
            limit_reg     <= 8'd50;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            zero_reg      <= 1'b0;
            sweep_reg     <= '0;
            change_reg    <= '0;
            status_reg    <= ST_LIMIT;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (reg_idx_t'(cfg_addr))
                    REG_VARS:  vars_reg  <= cfg_wdata[4:0];
                    REG_RELAX: relax_reg <= cfg_wdata;
                    REG_TOL:   tol_reg   <= cfg_wdata[15:0];
                    REG_LIMIT: limit_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    i_reg      <= '0;
                    zero_reg   <= 1'b0;
                    sweep_reg  <= '0;
                    change_reg <= '0;
                end
                S_CHK: begin
                    if (mat_rdata == '0) zero_reg <= 1'b1;
                    if (i_reg != n_last) i_reg <= i_reg + 5'd1;
                end
                S_DECIDE: begin
                    i_reg <= '0;
                    if (zero_reg || mat_rdata == '0) status_reg <= ST_ZERO_DIAG;
                    else status_reg <= ST_LIMIT;
                end
                S_ROW:  j_reg <= '0;
                S_ROWD: begin
                    acc_reg <= ACC_W'(signed'(mat_rdata));
                    old_reg <= sol_rdata;
                end
                S_RD:   if (j_reg == i_reg) j_reg <= j_reg + 5'd1;
                S_MUL:  prod_reg <= signed'(mat_rdata) * signed'(sol_rdata);
                S_ACC: begin
                    acc_reg <= acc_reg - ACC_W'(signed'(prod_reg[63:FRAC_BITS]));
                    j_reg   <= j_reg + 5'd1;
                end
                S_DIVLD: q_neg_reg <= res_sat[RES_W-1] ^ mat_rdata[DATA_W-1];
                S_DIV:   if (div_rsp.done) q_reg <= q_sat;
                S_STEP:  step_reg <= diff * signed'({1'b0, relax_reg});
                S_UPD: begin
                    change_reg <= change_new;
                    if (i_reg != n_last) i_reg <= i_reg + 5'd1;
                end
                S_SWEND: begin
                    sweep_reg  <= sweep_inc;
                    i_reg      <= '0;
                    change_reg <= '0;
                    if (change_reg < CHG_W'(tol_reg)) status_reg <= ST_CONVERGED;
                end
                S_OLD: begin
                    out_valid_reg <= 1'b1;
                    out_idx_reg   <= i_reg[3:0];
                    out_val_reg   <= sol_rdata;
                    out_last_reg  <= (i_reg == n_last);
                end
                S_OWAIT: begin
                    if (m_tready) begin
                        out_valid_reg <= 1'b0;
                        i_reg         <= i_reg + 5'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, sweep_reg, out_val_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = status_reg;

`include "sor_linear_solver_macros.svh"

    `SOR_ASSERT_ALWAYS(a_no_overlap, aclk, aresetn, !(s_tready && out_valid_reg))
    `SOR_ASSERT_NEXT(a_start_runs, aclk, aresetn, s_hs && s_tuser, state_reg == S_INIT)
    `SOR_ASSERT_NEXT(a_sweep_bound, aclk, aresetn, state_reg == S_SWEND, sweep_reg <= limit_reg)
    `SOR_ASSERT_NEXT(a_out_done, aclk, aresetn, m_hs && out_last_reg, state_reg == S_IDLE)

endmodule
